// File: sv/gregorian_date_serial_converter_assert.svh
// Assertion macros used by the date converter datapath.
`ifndef GREGORIAN_DATE_SERIAL_CONVERTER_ASSERT_SVH
`define GREGORIAN_DATE_SERIAL_CONVERTER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GDSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GDSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/gdsc_pkg.sv
// Types, constants and calendar tables of the date converter.
`default_nettype none

package gdsc_pkg;

  localparam int unsigned MAX_YEAR = 9999;

  localparam int unsigned DAY_W  = 5;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned YEAR_W = 14;
  localparam int unsigned SER_W  = 22;
  localparam int unsigned SUM_W  = SER_W + 1;
  localparam int unsigned CQ_W   = 8;   // (year - 1) / 100
  localparam int unsigned K_W    = 3;   // shift of the subtract step
  localparam int unsigned CUM_W  = 9;   // days before a month

  // floor(p / 100) == (p * 5243) >> 19 for every 14-bit p
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

  localparam logic [MON_W-1:0]  FEB    = 4'd2;
  localparam logic [MON_W-1:0]  MONTHS = 4'd12;
  localparam logic [SER_W-1:0]  DAYS_LEAP_YEAR = 22'd366;
  localparam logic [SUM_W-1:0]  DAYS_YEAR = 23'd365;

  typedef enum logic [1:0] {
    OP_TO_SERIAL = 2'd0,
    OP_TO_DATE   = 2'd1,
    OP_NEXT_DAY  = 2'd2
  } gdsc_op_e;

  typedef enum logic [1:0] {
    PH_400 = 2'd0,
    PH_100 = 2'd1,
    PH_4   = 2'd2,
    PH_1   = 2'd3
  } gdsc_phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV100,
    S_LEAP,
    S_D2S_MUL,
    S_D2S_ADD,
    S_S2D_INIT,
    S_S2D_DIV,
    S_S2D_DIV100,
    S_S2D_LEAP,
    S_MON,
    S_FINISH,
    S_FAIL
  } gdsc_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;
    logic div100;
    logic leap;
    logic d2s_mul;
    logic d2s_add;
    logic s2d_init;
    logic s2d_step;
    logic mon_init;
    logic mon_step;
    logic finish;
    logic fail;
  } gdsc_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       serial_zero;
    logic       date_bad;
    logic       sum_ovf;
    logic       div_last;
    logic       year_bad;
    logic       mon_last;
  } gdsc_sts_t;

  function automatic logic [DAY_W-1:0] gdsc_month_days(logic [MON_W-1:0] m, logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      FEB:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in a common year before the first of month m.
  function automatic logic [CUM_W-1:0] gdsc_days_before(logic [MON_W-1:0] m);
    logic [CUM_W-1:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // Days per 400, 100, 4 and 1 years.
  function automatic logic [SER_W-1:0] gdsc_div_den(gdsc_phase_e ph);
    logic [SER_W-1:0] d;
    case (ph)
      PH_400:  d = 22'd146097;
      PH_100:  d = 22'd36524;
      PH_4:    d = 22'd1461;
      default: d = 22'd365;
    endcase
    return d;
  endfunction

  function automatic logic [YEAR_W-1:0] gdsc_div_years(gdsc_phase_e ph);
    logic [YEAR_W-1:0] y;
    case (ph)
      PH_400:  y = 14'd400;
      PH_100:  y = 14'd100;
      PH_4:    y = 14'd4;
      default: y = 14'd1;
    endcase
    return y;
  endfunction

  // Top quotient bit per digit: 5 bits for 400y and 4y, 2 bits (clamps at 3) else.
  function automatic logic [K_W-1:0] gdsc_div_top(gdsc_phase_e ph);
    logic [K_W-1:0] k;
    case (ph)
      PH_400:  k = 3'd4;
      PH_4:    k = 3'd4;
      default: k = 3'd1;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// File: sv/gdsc_ctrl.sv
// Sequencing state machine of the date converter.
`default_nettype none

module gdsc_ctrl
  import gdsc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output gdsc_cmd_t cmd_o,
  input  gdsc_sts_t sts_i
);

  gdsc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (sts_i.op)
          OP_TO_SERIAL, OP_NEXT_DAY: state_d = S_DIV100;
          OP_TO_DATE:   state_d = sts_i.serial_zero ? S_FAIL : S_S2D_INIT;
          default:      state_d = S_FAIL;
        endcase
      end
      S_DIV100:  state_d = S_LEAP;
      S_LEAP:    state_d = S_D2S_MUL;
      S_D2S_MUL: state_d = sts_i.date_bad ? S_FAIL : S_D2S_ADD;
      S_D2S_ADD: begin
        if (sts_i.sum_ovf) begin
          state_d = S_FAIL;
        end else if (sts_i.op == OP_NEXT_DAY) begin
          state_d = S_S2D_INIT;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_S2D_INIT: state_d = S_S2D_DIV;
      S_S2D_DIV: begin
        if (sts_i.div_last) state_d = S_S2D_DIV100;
      end
      S_S2D_DIV100: state_d = sts_i.year_bad ? S_FAIL : S_S2D_LEAP;
      S_S2D_LEAP:   state_d = S_MON;
      S_MON: begin
        if (sts_i.mon_last) state_d = S_FINISH;
      end
      S_FINISH: state_d = S_IDLE;
      S_FAIL:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:       cmd_o.load = start_i;
      S_DIV100:     cmd_o.div100 = 1'b1;
      S_LEAP:       cmd_o.leap = 1'b1;
      S_D2S_MUL:    cmd_o.d2s_mul = 1'b1;
      S_D2S_ADD:    cmd_o.d2s_add = 1'b1;
      S_S2D_INIT:   cmd_o.s2d_init = 1'b1;
      S_S2D_DIV:    cmd_o.s2d_step = 1'b1;
      S_S2D_DIV100: cmd_o.div100 = 1'b1;
      S_S2D_LEAP: begin
        cmd_o.leap     = 1'b1;
        cmd_o.mon_init = 1'b1;
      end
      S_MON:        cmd_o.mon_step = 1'b1;
      S_FINISH:     cmd_o.finish = 1'b1;
      S_FAIL: begin
        cmd_o.finish = 1'b1;
        cmd_o.fail   = 1'b1;
      end
      default:      cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

// File: sv/gdsc_datapath.sv
// Date and day-number registers, divide steps and month walk of the converter.
`default_nettype none

`include "gregorian_date_serial_converter_assert.svh"

module gdsc_datapath
  import gdsc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gdsc_cmd_t         cmd_i,
  output gdsc_sts_t         sts_o,
  input  logic [1:0]        command_i,
  input  logic [DAY_W-1:0]  in_day_i,
  input  logic [MON_W-1:0]  in_month_i,
  input  logic [YEAR_W-1:0] in_year_i,
  input  logic [SER_W-1:0]  in_serial_i,
  output logic              done_o,
  output logic [DAY_W-1:0]  out_day_o,
  output logic [MON_W-1:0]  out_month_o,
  output logic [YEAR_W-1:0] out_year_o,
  output logic [SER_W-1:0]  out_serial_o,
  output logic              range_error_o
);

  // working registers
  logic [1:0]        op_q;
  logic [DAY_W-1:0]  day_q;
  logic [MON_W-1:0]  mon_q;
  logic [YEAR_W-1:0] p_q;        // year - 1
  logic [SER_W-1:0]  serial_q;
  logic [SER_W-1:0]  r_q;        // remaining days
  logic [CQ_W-1:0]   cq_q;       // p / 100
  logic              leap_q;
  logic [SUM_W-1:0]  a_q;        // 365 * p
  logic [YEAR_W-1:0] b_q;        // leap days + days into the year
  gdsc_phase_e       phase_q;
  logic [K_W-1:0]    k_q;

  // result registers
  logic              done_q;
  logic [DAY_W-1:0]  out_day_q;
  logic [MON_W-1:0]  out_month_q;
  logic [YEAR_W-1:0] out_year_q;
  logic [SER_W-1:0]  out_serial_q;
  logic              range_error_q;

  logic [YEAR_W+RECIP_W-1:0] prod100;
  logic [YEAR_W-1:0] cq_ext, hund, r100;
  logic              leap_d;
  logic [SUM_W-1:0]  a_d, sum;
  logic [YEAR_W-1:0] b_d;
  logic              leap_adj;
  logic [DAY_W-1:0]  mdays;
  logic [SER_W-1:0]  cand;
  logic [YEAR_W-1:0] yr_inc;
  logic              take;
  logic              div_last, year_bad, mon_last, date_bad;

  // p / 100 by reciprocal, registered before use
  assign prod100 = {{RECIP_W{1'b0}}, p_q} * {{YEAR_W{1'b0}}, RECIP_100};

  // leap test on y = p + 1: p % 4 == 3, and p % 100 != 99 unless (p / 100) % 4 == 3
  assign cq_ext = YEAR_W'(cq_q);
  assign hund   = (cq_ext << 6) + (cq_ext << 5) + (cq_ext << 2);
  assign r100   = p_q - hund;
  assign leap_d = (p_q[1:0] == 2'b11) && ((r100 != 14'd99) || (cq_q[1:0] == 2'b11));

  assign mdays    = gdsc_month_days(mon_q, leap_q);
  assign leap_adj = leap_q && (mon_q > FEB);

  assign a_d = {{(SUM_W-YEAR_W){1'b0}}, p_q} * DAYS_YEAR;
  assign b_d = (p_q >> 2) - cq_ext + (cq_ext >> 2)
             + YEAR_W'(gdsc_days_before(mon_q))
             + YEAR_W'(leap_adj) + YEAR_W'(day_q);
  assign sum = a_q + SUM_W'(b_q) + SUM_W'(op_q == OP_NEXT_DAY);

  // one restoring step of the 400/100/4/1-year split
  assign cand     = gdsc_div_den(phase_q) << k_q;
  assign yr_inc   = gdsc_div_years(phase_q) << k_q;
  assign take     = (r_q >= cand);
  assign div_last = (phase_q == PH_1) && (k_q == '0);

  assign year_bad = (p_q >= YEAR_W'(MAX_YEAR));
  assign mon_last = !((r_q >= SER_W'(mdays)) && (mon_q < MONTHS));
  assign date_bad = year_bad || (mon_q == '0) || (mon_q > MONTHS)
                 || (day_q == '0) || (day_q > mdays);

  always_comb begin
    sts_o.op          = op_q;
    sts_o.serial_zero = (serial_q == '0);
    sts_o.date_bad    = date_bad;
    sts_o.sum_ovf     = sum[SUM_W-1];
    sts_o.div_last    = div_last;
    sts_o.year_bad    = year_bad;
    sts_o.mon_last    = mon_last;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= command_i;
      day_q    <= in_day_i;
      mon_q    <= in_month_i;
      p_q      <= in_year_i - 14'd1;
      serial_q <= in_serial_i;
    end
    if (cmd_i.div100) cq_q <= prod100[RECIP_SHIFT +: CQ_W];
    if (cmd_i.leap)   leap_q <= leap_d;
    if (cmd_i.d2s_mul) begin
      a_q <= a_d;
      b_q <= b_d;
    end
    if (cmd_i.d2s_add) serial_q <= sum[SER_W-1:0];
    if (cmd_i.s2d_init) begin
      r_q     <= serial_q - 22'd1;
      p_q     <= '0;
      phase_q <= PH_400;
      k_q     <= gdsc_div_top(PH_400);
    end
    if (cmd_i.s2d_step) begin
      if (take) begin
        r_q <= r_q - cand;
        p_q <= p_q + yr_inc;
      end
      if (k_q == '0) begin
        phase_q <= gdsc_phase_e'(phase_q + 2'd1);
        k_q     <= gdsc_div_top(gdsc_phase_e'(phase_q + 2'd1));
      end else begin
        k_q <= k_q - 3'd1;
      end
    end
    if (cmd_i.mon_init) mon_q <= 4'd1;
    if (cmd_i.mon_step) begin
      if (!mon_last) begin
        r_q   <= r_q - SER_W'(mdays);
        mon_q <= mon_q + 4'd1;
      end else begin
        day_q <= r_q[DAY_W-1:0] + 5'd1;
      end
    end
    if (cmd_i.finish) begin
      out_day_q     <= cmd_i.fail ? '0 : day_q;
      out_month_q   <= cmd_i.fail ? '0 : mon_q;
      out_year_q    <= cmd_i.fail ? '0 : p_q + 14'd1;
      out_serial_q  <= cmd_i.fail ? '0 : serial_q;
      range_error_q <= cmd_i.fail;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  assign done_o        = done_q;
  assign out_day_o     = out_day_q;
  assign out_month_o   = out_month_q;
  assign out_year_o    = out_year_q;
  assign out_serial_o  = out_serial_q;
  assign range_error_o = range_error_q;

  `GDSC_ASSERT_NOW(a_mon_range, cmd_i.mon_step, (mon_q != '0) && (mon_q <= MONTHS), "month walk left 1..12")
  `GDSC_ASSERT_NEXT(a_div_rem, cmd_i.s2d_step && div_last, r_q < DAYS_LEAP_YEAR, "day of year too large after split")
  `GDSC_ASSERT_NEXT(a_serial_pos, cmd_i.d2s_add && !sum[SUM_W-1], serial_q != '0, "computed day number is zero")
  `GDSC_ASSERT_NOW(a_out_date, done_q && !range_error_q, (out_month_q != '0) && (out_month_q <= MONTHS) && (out_day_q != '0) && (out_day_q <= gdsc_month_days(out_month_q, 1'b1)), "good beat with impossible date")

endmodule

`default_nettype wire

// File: sv/gregorian_date_serial_converter.sv
// Top level of the proleptic Gregorian date / day-number converter.
`default_nettype none

// Converts between a calendar date and a day number (0001-01-01 is day 1)
// in the proleptic Gregorian calendar, or gives the day after a date.
// An item is taken on a rising edge with start high and busy low; busy stays
// high until the result is published. The result beat shows on the output
// ports for exactly one cycle with done_o high and cannot be held off, so
// sample it on that edge. busy is already low in the done_o cycle, so the
// next item may be issued there. Errors end early. The day-number to date
// leg splits the count into 400-, 100-, 4- and 1-year blocks by single-step
// compare/subtract, then walks the months one month per cycle (up to 12).
// The date to day-number leg is one registered 14x13 reciprocal multiply
// for (year-1)/100, one for 365*(year-1), and one 23-bit add.
// Invalid dates, day number zero, command 3, a year past MAX_YEAR or a day
// number that does not fit 22 bits give range_error_o with all fields zero.
// No memories and no clearing pass; the block is ready right after reset.
module gregorian_date_serial_converter
  import gdsc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command_i,
  input  logic [DAY_W-1:0]  in_day_i,
  input  logic [MON_W-1:0]  in_month_i,
  input  logic [YEAR_W-1:0] in_year_i,
  input  logic [SER_W-1:0]  in_serial_i,
  output logic              done_o,
  output logic [DAY_W-1:0]  out_day_o,
  output logic [MON_W-1:0]  out_month_o,
  output logic [YEAR_W-1:0] out_year_o,
  output logic [SER_W-1:0]  out_serial_o,
  output logic              range_error_o
);

  gdsc_cmd_t cmd;   // per-state datapath enables
  gdsc_sts_t sts;   // decode and loop-exit flags back to the sequencer

  gdsc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  gdsc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .command_i     (command_i),
    .in_day_i      (in_day_i),
    .in_month_i    (in_month_i),
    .in_year_i     (in_year_i),
    .in_serial_i   (in_serial_i),
    .done_o        (done_o),
    .out_day_o     (out_day_o),
    .out_month_o   (out_month_o),
    .out_year_o    (out_year_o),
    .out_serial_o  (out_serial_o),
    .range_error_o (range_error_o)
  );

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for the Gregorian date / day-number converter.
module tb;
  import gdsc_pkg::*;

  // Command 3 has no enum member in the package; name it here.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned SERIAL_MAX    = (1 << SER_W) - 1;
  localparam int unsigned DAYS_PER_400Y = 146097;
  localparam int unsigned DAYS_PER_100Y = 36524;
  localparam int unsigned DAYS_PER_4Y   = 1461;
  localparam int unsigned DAYS_PER_YEAR = 365;

  // Margin after the last answer, longer than the longest item.
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned ITEMS_PER_PHASE = 375;

  typedef struct {
    logic [1:0]        command;
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic [SER_W-1:0]  serial;
  } date_cmd_t;

  typedef struct {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic [SER_W-1:0]  serial;
    logic              err;
  } calendar_answer_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start       = 1'b0;
  logic [1:0]        command_i   = '0;
  logic [DAY_W-1:0]  in_day_i    = '0;
  logic [MON_W-1:0]  in_month_i  = '0;
  logic [YEAR_W-1:0] in_year_i   = '0;
  logic [SER_W-1:0]  in_serial_i = '0;
  logic              busy;
  logic              done_o;
  logic [DAY_W-1:0]  out_day_o;
  logic [MON_W-1:0]  out_month_o;
  logic [YEAR_W-1:0] out_year_o;
  logic [SER_W-1:0]  out_serial_o;
  logic              range_error_o;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  gregorian_date_serial_converter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .in_day_i      (in_day_i),
    .in_month_i    (in_month_i),
    .in_year_i     (in_year_i),
    .in_serial_i   (in_serial_i),
    .done_o        (done_o),
    .out_day_o     (out_day_o),
    .out_month_o   (out_month_o),
    .out_year_o    (out_year_o),
    .out_serial_o  (out_serial_o),
    .range_error_o (range_error_o)
  );

  // ---------------------------------------------------------------------------
  // Calendar arithmetic, proleptic Gregorian, day 1 = 0001-01-01.
  // ---------------------------------------------------------------------------
  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned month_length(int unsigned y, int unsigned m);
    int unsigned len;
    case (m)
      2:           len = leap_year(y) ? 29 : 28;
      4, 6, 9, 11: len = 30;
      default:     len = 31;
    endcase
    return len;
  endfunction

  // Caller guarantees a valid date.
  function automatic int unsigned day_number(int unsigned d, int unsigned m,
                                             int unsigned y);
    int unsigned p;
    int unsigned n;
    int unsigned mo;
    p = y - 1;
    n = DAYS_PER_YEAR * p + p / 4 - p / 100 + p / 400;
    for (mo = 1; mo < m; mo++) begin
      n += month_length(y, mo);
    end
    return n + d;
  endfunction

  // Split the count into 400/100/4/1-year blocks, then walk the months.
  // The 100y and 1y digits clamp at 3: the last day of a 400y (or 4y)
  // block would otherwise roll into a fifth century (or year).
  function automatic void date_of(input int unsigned s, output int unsigned d,
                                  output int unsigned m, output int unsigned y);
    int unsigned n;
    int unsigned q400;
    int unsigned q100;
    int unsigned q4;
    int unsigned q1;
    int unsigned r;
    int unsigned mo;
    n    = s - 1;
    q400 = n / DAYS_PER_400Y;
    r    = n % DAYS_PER_400Y;
    q100 = r / DAYS_PER_100Y;
    if (q100 > 3) q100 = 3;
    r   -= q100 * DAYS_PER_100Y;
    q4   = r / DAYS_PER_4Y;
    r    = r % DAYS_PER_4Y;
    q1   = r / DAYS_PER_YEAR;
    if (q1 > 3) q1 = 3;
    r   -= q1 * DAYS_PER_YEAR;
    y    = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
    mo   = 1;
    while (r >= month_length(y, mo) && mo < 12) begin
      r -= month_length(y, mo);
      mo++;
    end
    m = mo;
    d = r + 1;
  endfunction

  // Expected answer for one command beat. Any failure zeroes every field
  // and raises the error flag.
  function automatic calendar_answer_t convert_date_cmd(date_cmd_t c);
    calendar_answer_t a;
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned s;
    bit bad;
    d   = 32'(c.day);
    m   = 32'(c.month);
    y   = 32'(c.year);
    s   = 32'(c.serial);
    bad = 1'b0;
    case (c.command)
      OP_TO_SERIAL, OP_NEXT_DAY: begin
        if (y < 1 || y > MAX_YEAR || m < 1 || m > 12 || d < 1 ||
            d > month_length(y, m)) begin
          bad = 1'b1;
        end else begin
          s = day_number(d, m, y);
          if (c.command == OP_NEXT_DAY) begin
            s++;
            date_of(s, d, m, y);
            if (y > MAX_YEAR) bad = 1'b1;
          end
          if (s > SERIAL_MAX) bad = 1'b1;
        end
      end
      OP_TO_DATE: begin
        if (s == 0) begin
          bad = 1'b1;
        end else begin
          date_of(s, d, m, y);
          if (y > MAX_YEAR) bad = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      a = '{day: '0, month: '0, year: '0, serial: '0, err: 1'b1};
    end else begin
      a.day    = d[DAY_W-1:0];
      a.month  = m[MON_W-1:0];
      a.year   = y[YEAR_W-1:0];
      a.serial = s[SER_W-1:0];
      a.err    = 1'b0;
    end
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Random commands. One in five is pure noise over every field (command 3,
  // bad dates, day zero, out-of-range years); the rest are well formed with
  // unused fields left random, biased toward month ends, century and 400y
  // boundaries and the top of the supported range.
  // ---------------------------------------------------------------------------
  function automatic date_cmd_t random_cmd(int unsigned last_day);
    date_cmd_t c;
    int unsigned pick;
    int unsigned roll;
    int unsigned y;
    int unsigned m;
    c.command = 2'($urandom_range(3));
    c.day     = DAY_W'($urandom_range(31));
    c.month   = MON_W'($urandom_range(15));
    c.year    = YEAR_W'($urandom_range(16383));
    c.serial  = SER_W'($urandom_range(SERIAL_MAX));
    pick = $urandom_range(99);
    roll = $urandom_range(99);
    if (pick < 20) return c;
    if (pick < 45) begin
      c.command = OP_TO_DATE;
      if (roll < 15) begin
        c.serial = SER_W'(last_day + 400 - $urandom_range(800));
      end else if (roll < 30) begin
        c.serial = SER_W'($urandom_range(24, 1) * DAYS_PER_400Y + $urandom_range(2) - 1);
      end else begin
        c.serial = SER_W'($urandom_range(last_day, 1));
      end
      return c;
    end
    c.command = (pick < 75) ? OP_TO_SERIAL : OP_NEXT_DAY;
    if (roll < 10)      y = MAX_YEAR - $urandom_range(3);
    else if (roll < 20) y = $urandom_range(4, 1);
    else if (roll < 35) y = 100 * $urandom_range(MAX_YEAR / 100, 1);
    else                y = $urandom_range(MAX_YEAR, 1);
    m = $urandom_range(12, 1);
    c.year  = YEAR_W'(y);
    c.month = MON_W'(m);
    c.day   = DAY_W'(($urandom_range(99) < 30) ? month_length(y, m)
                                               : $urandom_range(month_length(y, m), 1));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one beat in flight on the command port. Inputs move on the
  // falling edge only. A beat stays up until the rising edge that sees
  // start high and busy low, tracked by the offered/taken counters.
  // ---------------------------------------------------------------------------
  date_cmd_t        date_cmd_q[$];
  calendar_answer_t answers_q[$];
  int unsigned      sender_idle_pct = 0;
  int unsigned      beats_offered   = 0;
  int unsigned      beats_taken     = 0;
  int unsigned      results_seen    = 0;
  int unsigned      flagged_seen    = 0;
  int unsigned      mismatches      = 0;
  int unsigned      cmd_seen[4]     = '{0, 0, 0, 0};

  always @(negedge clk_i) begin
    // Slot is free unless the current beat is still waiting for busy to drop.
    if (rst_ni && !(start && beats_taken != beats_offered)) begin
      if (date_cmd_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        command_i   <= date_cmd_q[0].command;
        in_day_i    <= date_cmd_q[0].day;
        in_month_i  <= date_cmd_q[0].month;
        in_year_i   <= date_cmd_q[0].year;
        in_serial_i <= date_cmd_q[0].serial;
        void'(date_cmd_q.pop_front());
        start <= 1'b1;
        beats_offered++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge, first check a finishing result against the
  // oldest prediction, then log a newly taken beat. The order matters since a
  // new beat may be taken in the very cycle the previous result is published.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin : observe
      calendar_answer_t want;
      date_cmd_t        taken;
      if (done_o) begin
        results_seen++;
        if (range_error_o) flagged_seen++;
        if (answers_q.size() == 0) begin
          $error("result beat with no command outstanding");
          mismatches++;
        end else begin
          want = answers_q.pop_front();
          if (out_day_o !== want.day) begin
            $error("out_day expected %0d got %0d", want.day, out_day_o);
            mismatches++;
          end
          if (out_month_o !== want.month) begin
            $error("out_month expected %0d got %0d", want.month, out_month_o);
            mismatches++;
          end
          if (out_year_o !== want.year) begin
            $error("out_year expected %0d got %0d", want.year, out_year_o);
            mismatches++;
          end
          if (out_serial_o !== want.serial) begin
            $error("out_serial expected %0d got %0d", want.serial, out_serial_o);
            mismatches++;
          end
          if (range_error_o !== want.err) begin
            $error("range_error expected %0d got %0d", want.err, range_error_o);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        taken.command = command_i;
        taken.day     = in_day_i;
        taken.month   = in_month_i;
        taken.year    = in_year_i;
        taken.serial  = in_serial_i;
        answers_q.push_back(convert_date_cmd(taken));
        cmd_seen[command_i]++;
        beats_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(logic [1:0] cmd, int unsigned d, int unsigned m,
                           int unsigned y, int unsigned s);
    date_cmd_t c;
    c.command = cmd;
    c.day     = DAY_W'(d);
    c.month   = MON_W'(m);
    c.year    = YEAR_W'(y);
    c.serial  = SER_W'(s);
    date_cmd_q.push_back(c);
  endtask

  initial begin : stimulus
    int unsigned last_day;
    int unsigned idle_plan[3];
    int unsigned ph;
    idle_plan = '{0, 51, 25};
    last_day  = day_number(31, 12, MAX_YEAR);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: range ends, leap rules, invalid dates, every command.
    queue_cmd(OP_TO_SERIAL, 1, 1, 1, 0);
    queue_cmd(OP_TO_SERIAL, 31, 12, MAX_YEAR, SERIAL_MAX);  // serial ignored
    queue_cmd(OP_TO_SERIAL, 29, 2, 2000, 0);                // 400y leap
    queue_cmd(OP_TO_SERIAL, 29, 2, 1900, 0);                // century, not leap
    queue_cmd(OP_TO_SERIAL, 29, 2, 2004, 0);
    queue_cmd(OP_TO_SERIAL, 0, 5, 2020, 0);                 // day zero
    queue_cmd(OP_TO_SERIAL, 31, 4, 2021, 0);                // past month end
    queue_cmd(OP_TO_SERIAL, 15, 0, 2021, 0);                // month zero
    queue_cmd(OP_TO_SERIAL, 15, 13, 2021, 0);
    queue_cmd(OP_TO_SERIAL, 31, 15, 16383, SERIAL_MAX);     // every bit high
    queue_cmd(OP_TO_SERIAL, 1, 1, 0, 0);                    // year zero
    queue_cmd(OP_TO_SERIAL, 1, 1, MAX_YEAR + 1, 0);
    queue_cmd(OP_TO_DATE, 0, 0, 0, 0);                      // day number zero
    queue_cmd(OP_TO_DATE, 31, 15, 16383, 1);                // date fields ignored
    queue_cmd(OP_TO_DATE, 0, 0, 0, last_day);
    queue_cmd(OP_TO_DATE, 0, 0, 0, last_day + 1);           // past last year
    queue_cmd(OP_TO_DATE, 0, 0, 0, SERIAL_MAX);
    queue_cmd(OP_TO_DATE, 0, 0, 0, DAYS_PER_400Y);          // 100y digit clamps
    queue_cmd(OP_TO_DATE, 0, 0, 0, DAYS_PER_4Y);            // 1y digit clamps
    queue_cmd(OP_NEXT_DAY, 31, 12, MAX_YEAR, 0);            // rolls out of range
    queue_cmd(OP_NEXT_DAY, 28, 2, 2000, 0);
    queue_cmd(OP_NEXT_DAY, 28, 2, 1900, 0);
    queue_cmd(OP_NEXT_DAY, 31, 12, 2023, SERIAL_MAX);
    queue_cmd(OP_NEXT_DAY, 30, 2, 2024, 0);                 // invalid input
    queue_cmd(OP_UNUSED, 31, 15, 16383, SERIAL_MAX);

    // Random phases: back to back, sender idle about half the time, then
    // idle a quarter of the time. The result side has no stall to apply.
    for (ph = 0; ph < 3; ph++) begin
      sender_idle_pct = idle_plan[ph];
      repeat (ITEMS_PER_PHASE) date_cmd_q.push_back(random_cmd(last_day));
      while (date_cmd_q.size() != 0 || beats_taken != beats_offered) begin
        @(posedge clk_i);
      end
    end

    while (answers_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d conversions: %0d date->number, %0d number->date,",
             beats_taken, cmd_seen[OP_TO_SERIAL], cmd_seen[OP_TO_DATE]);
    $display("  %0d next-day, %0d unused command; %0d results flagged in error.",
             cmd_seen[OP_NEXT_DAY], cmd_seen[OP_UNUSED], flagged_seen);
    if (mismatches == 0 && results_seen == beats_taken) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: well over the slowest legal run of about 1200 beats.
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: gregorian_date_serial_converter.f
+incdir+sv
sv/gdsc_pkg.sv
sv/gdsc_ctrl.sv
sv/gdsc_datapath.sv
sv/gregorian_date_serial_converter.sv
bench/tb.sv
